/* sv/ibpr_pkg.sv */
`default_nettype none
package ibpr_pkg;

  // fixed field widths
  localparam int PIX_W    = 8;
  localparam int WIDTH_W  = 11;
  localparam int HEIGHT_W = 16;
  localparam int ROW_W    = HEIGHT_W + 1;

  // default line store depth
  localparam int MAX_WIDTH_DEF = 1024;

  // pixel levels
  localparam logic [PIX_W-1:0] PIX_BLACK = 8'h00;
  localparam logic [PIX_W-1:0] PIX_WHITE = 8'hFF;

  // register reset values and lower limit
  localparam logic [WIDTH_W-1:0]  WIDTH_RST  = 11'd640;
  localparam logic [HEIGHT_W-1:0] HEIGHT_RST = 16'd480;
  localparam logic [WIDTH_W-1:0]  WIDTH_MIN  = 11'd3;
  localparam logic [HEIGHT_W-1:0] HEIGHT_MIN = 16'd3;

  // register file
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam logic REG_FRAME_WIDTH  = 1'b0;
  localparam logic REG_FRAME_HEIGHT = 1'b1;

  // per-item control carried down the pipe
  typedef struct packed {
    logic emit;
    logic interior;
    logic last;
  } ibpr_tag_t;

endpackage
`default_nettype wire

/* sv/ibpr_if.sv */
`default_nettype none
interface ibpr_in_if;
  import ibpr_pkg::*;
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel_in;
  logic             is_fill;

  modport source (output valid, output pixel_in, output is_fill, input ready);
  modport sink   (input valid, input pixel_in, input is_fill, output ready);
endinterface

interface ibpr_out_if;
  import ibpr_pkg::*;
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel_out;
  logic             last_of_frame;

  modport source (output valid, output pixel_out, output last_of_frame, input ready);
  modport sink   (input valid, input pixel_out, input last_of_frame, output ready);
endinterface
`default_nettype wire

/* sv/ibpr_cfg.sv */
`default_nettype none
module ibpr_cfg
  import ibpr_pkg::*;
#(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [CFG_ADDR_W-1:0] paddr,
  input  wire logic [CFG_DATA_W-1:0] pwdata,
  output logic      [CFG_DATA_W-1:0] prdata,
  output logic                       pready,
  output logic      [WIDTH_W-1:0]    frame_width,
  output logic      [HEIGHT_W-1:0]   frame_height,
  output logic                       restart
);

  logic [WIDTH_W-1:0]  width_r, width_nxt;
  logic [HEIGHT_W-1:0] height_r, height_nxt;
  logic [WIDTH_W-1:0]  wr_width;
  logic [HEIGHT_W-1:0] wr_height;
  logic                wr_en;
  logic                reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[2];
  assign restart = wr_en;

  // clamp written values to the supported range
  always_comb begin
    wr_width  = pwdata[WIDTH_W-1:0];
    wr_height = pwdata[HEIGHT_W-1:0];
    if (wr_width < WIDTH_MIN) begin
      wr_width = WIDTH_MIN;
    end else if (32'(wr_width) > 32'(MAX_WIDTH)) begin
      wr_width = WIDTH_W'(MAX_WIDTH);
    end
    if (wr_height < HEIGHT_MIN) begin
      wr_height = HEIGHT_MIN;
    end
  end

  always_comb begin
    width_nxt  = width_r;
    height_nxt = height_r;
    if (wr_en) begin
      case (reg_idx)
        REG_FRAME_WIDTH:  width_nxt  = wr_width;
        REG_FRAME_HEIGHT: height_nxt = wr_height;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WIDTH_RST;
      height_r <= HEIGHT_RST;
    end else begin
      width_r  <= width_nxt;
      height_r <= height_nxt;
    end
  end

  // read back
  always_comb begin
    case (reg_idx)
      REG_FRAME_WIDTH:  prdata = CFG_DATA_W'(width_r);
      REG_FRAME_HEIGHT: prdata = CFG_DATA_W'(height_r);
      default:          prdata = '0;
    endcase
  end

  assign frame_width  = width_r;
  assign frame_height = height_r;

endmodule
`default_nettype wire

/* sv/ibpr_ctrl.sv */
`default_nettype none
module ibpr_ctrl
  import ibpr_pkg::*;
#(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF,
  localparam int COL_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1,
  localparam int CMP_W = ((COL_W > WIDTH_W) ? COL_W : WIDTH_W) + 1
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                fire,
  input  wire logic [PIX_W-1:0]    pixel_in,
  input  wire logic                is_fill,
  input  wire logic [WIDTH_W-1:0]  frame_width,
  input  wire logic [HEIGHT_W-1:0] frame_height,
  input  wire logic                restart,
  output logic                     step,
  output logic      [COL_W-1:0]    col,
  output logic      [PIX_W-1:0]    pix,
  output ibpr_tag_t                tag
);

  logic [COL_W-1:0]    in_col_r, in_col_nxt;
  logic [ROW_W-1:0]    in_row_r, in_row_nxt;
  logic [COL_W-1:0]    out_col_r, out_col_nxt;
  logic [HEIGHT_W-1:0] out_row_r, out_row_nxt;
  logic                in_frame;
  logic                in_wrap;
  logic                out_col_end;
  logic                out_row_end;
  logic [CMP_W-1:0]    width_ext;
  logic [ROW_W-1:0]    height_ext;
  logic [ROW_W-1:0]    out_row_p1;

  assign width_ext  = CMP_W'(frame_width);
  assign height_ext = ROW_W'(frame_height);
  assign out_row_p1 = ROW_W'(out_row_r) + 1'b1;

  // fill beats inside the frame are dropped, pixels after it are flush
  assign in_frame = in_row_r < height_ext;
  assign step     = fire && !(in_frame && is_fill);
  assign pix      = in_frame ? pixel_in : PIX_BLACK;
  assign col      = in_col_r;

  // position tests
  assign in_wrap     = (CMP_W'(in_col_r) + 1'b1) >= width_ext;
  assign out_col_end = (CMP_W'(out_col_r) + 1'b1) >= width_ext;
  assign out_row_end = out_row_p1 >= height_ext;

  always_comb begin
    tag.emit     = (in_row_r > ROW_W'(1)) || (in_row_r == ROW_W'(1) && in_col_r != '0);
    tag.interior = (out_row_r != '0) && !out_row_end && (out_col_r != '0) && !out_col_end;
    tag.last     = out_row_end && out_col_end;
  end

  // counter update
  always_comb begin
    in_col_nxt  = in_col_r;
    in_row_nxt  = in_row_r;
    out_col_nxt = out_col_r;
    out_row_nxt = out_row_r;
    if (restart || (step && tag.emit && tag.last)) begin
      in_col_nxt  = '0;
      in_row_nxt  = '0;
      out_col_nxt = '0;
      out_row_nxt = '0;
    end else if (step) begin
      if (in_wrap) begin
        in_col_nxt = '0;
        in_row_nxt = in_row_r + 1'b1;
      end else begin
        in_col_nxt = in_col_r + 1'b1;
      end
      if (tag.emit) begin
        if (out_col_end) begin
          out_col_nxt = '0;
          out_row_nxt = out_row_r + 1'b1;
        end else begin
          out_col_nxt = out_col_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_col_r  <= '0;
      in_row_r  <= '0;
      out_col_r <= '0;
      out_row_r <= '0;
    end else begin
      in_col_r  <= in_col_nxt;
      in_row_r  <= in_row_nxt;
      out_col_r <= out_col_nxt;
      out_row_r <= out_row_nxt;
    end
  end

endmodule
`default_nettype wire

/* sv/ibpr_linebuf.sv */
`default_nettype none
module ibpr_linebuf
  import ibpr_pkg::*;
#(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF,
  localparam int COL_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             step,
  input  wire logic [COL_W-1:0] col,
  input  wire logic [PIX_W-1:0] pix,
  input  wire ibpr_tag_t        tag,
  input  wire logic             s1_adv,
  output logic                  s1_valid,
  output ibpr_tag_t             s1_tag,
  output logic      [PIX_W-1:0] s1_pix,
  output logic      [PIX_W-1:0] col_up,
  output logic      [PIX_W-1:0] col_mid
);

  logic [PIX_W-1:0] upper_mem [0:MAX_WIDTH-1];
  logic [PIX_W-1:0] middle_mem [0:MAX_WIDTH-1];

  logic             s1_valid_r, s1_valid_nxt;
  logic [COL_W-1:0] s1_col_r;
  logic [PIX_W-1:0] s1_pix_r;
  ibpr_tag_t        s1_tag_r;
  logic [PIX_W-1:0] rd_up_r, rd_mid_r;
  logic             fwd_r;
  logic [PIX_W-1:0] fwd_up_r, fwd_mid_r;

  // stage occupancy
  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (step) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      fwd_r      <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      if (step) begin
        fwd_r <= s1_valid_r && (s1_col_r == col);
      end
    end
  end

  // stage payload and bypass of the write that lands on the entry being read
  always_ff @(posedge clk) begin
    if (step) begin
      s1_col_r  <= col;
      s1_pix_r  <= pix;
      s1_tag_r  <= tag;
      fwd_up_r  <= col_mid;
      fwd_mid_r <= s1_pix_r;
    end
  end

  // line stores: read on accept, write back when the stage retires
  always_ff @(posedge clk) begin
    if (step) begin
      rd_up_r  <= upper_mem[col];
      rd_mid_r <= middle_mem[col];
    end
    if (s1_valid_r && s1_adv) begin
      upper_mem[s1_col_r]  <= col_mid;
      middle_mem[s1_col_r] <= s1_pix_r;
    end
  end

  assign col_up   = fwd_r ? fwd_up_r : rd_up_r;
  assign col_mid  = fwd_r ? fwd_mid_r : rd_mid_r;
  assign s1_valid = s1_valid_r;
  assign s1_tag   = s1_tag_r;
  assign s1_pix   = s1_pix_r;

endmodule
`default_nettype wire

/* sv/ibpr_window.sv */
`default_nettype none
module ibpr_window
  import ibpr_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             s1_valid,
  input  wire ibpr_tag_t        s1_tag,
  input  wire logic [PIX_W-1:0] s1_pix,
  input  wire logic [PIX_W-1:0] col_up,
  input  wire logic [PIX_W-1:0] col_mid,
  output logic                  s1_adv,
  output logic                  out_valid,
  output logic      [PIX_W-1:0] out_pixel,
  output logic                  out_last,
  input  wire logic             out_ready
);

  logic [PIX_W-1:0] win_r   [0:2][0:2];
  logic [PIX_W-1:0] win_nxt [0:2][0:2];
  logic             out_valid_r, out_valid_nxt;
  logic [PIX_W-1:0] out_pixel_r;
  logic             out_last_r;
  logic             isolated;
  logic [PIX_W-1:0] result;
  logic             shift;
  logic             load;

  // stage retires unless it carries a beat and the output slot is held
  assign s1_adv = s1_valid && (!s1_tag.emit || !out_valid_r || out_ready);
  assign shift  = s1_adv;
  assign load   = s1_adv && s1_tag.emit;

  // window after shifting in the new column
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      win_nxt[r][0] = win_r[r][1];
      win_nxt[r][1] = win_r[r][2];
    end
    win_nxt[0][2] = col_up;
    win_nxt[1][2] = col_mid;
    win_nxt[2][2] = s1_pix;
  end

  // black centre with all eight neighbours white
  always_comb begin
    isolated = (win_nxt[1][1] == PIX_BLACK);
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        if ((r != 1 || c != 1) && win_nxt[r][c] != PIX_WHITE) begin
          isolated = 1'b0;
        end
      end
    end
    result = (s1_tag.interior && isolated) ? PIX_WHITE : win_nxt[1][1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          win_r[r][c] <= '0;
        end
      end
    end else if (shift) begin
      win_r <= win_nxt;
    end
  end

  // output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_pixel_r <= result;
      out_last_r  <= s1_tag.last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_pixel = out_pixel_r;
  assign out_last  = out_last_r;

endmodule
`default_nettype wire

/* sv/isolated_black_pixel_removal_top.sv */
// Isolated black pixel removal over a 3x3 window.
// in_bus takes one grey pixel per beat in raster order; out_bus gives the
// filtered pixels in the same order, last_of_frame marking the final one.
// A black pixel whose eight neighbours are all white comes out white; all
// other pixels, and the whole outer border, pass unchanged.
// Results lag the input by one line plus one pixel: after each frame the
// source sends frame_width+1 beats with is_fill set to push them out. Fill
// beats sent inside the frame are dropped.
// One beat per cycle is taken in steady state; the beat completing a
// window reaches out_bus via the read stage and the output register. The
// rate is set by the two line stores, each with one read and one write
// port per cycle. If the receiver stalls, the output register holds and
// the read stage stalls behind it, so in_bus.ready falls; nothing is lost.
// Reset clears the positions to the frame start and sets 640 x 480; the
// line store contents are undefined until written. The user must write
// frame_width (addr 0) and frame_height (addr 4) over the APB port only
// while idle; the block does not enforce it. A write restarts the frame.
`default_nettype none
module isolated_black_pixel_removal_top
  import ibpr_pkg::*;
#(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  ibpr_in_if.sink                    in_bus,
  ibpr_out_if.source                 out_bus,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [CFG_ADDR_W-1:0] paddr,
  input  wire logic [CFG_DATA_W-1:0] pwdata,
  output logic      [CFG_DATA_W-1:0] prdata,
  output logic                       pready
);

  localparam int COL_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

  logic [WIDTH_W-1:0]  frame_width;
  logic [HEIGHT_W-1:0] frame_height;
  logic                restart;
  logic                fire;
  logic                step;
  logic [COL_W-1:0]    col;
  logic [PIX_W-1:0]    pix;
  ibpr_tag_t           tag;
  logic                s1_valid;
  logic                s1_adv;
  ibpr_tag_t           s1_tag;
  logic [PIX_W-1:0]    s1_pix;
  logic [PIX_W-1:0]    col_up;
  logic [PIX_W-1:0]    col_mid;

  // accept whenever the read stage is free or retiring
  assign in_bus.ready = !s1_valid || s1_adv;
  assign fire         = in_bus.valid && in_bus.ready;

  ibpr_cfg #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_cfg (
    .clk          (clk),
    .rst_n        (rst_n),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .frame_width  (frame_width),
    .frame_height (frame_height),
    .restart      (restart)
  );

  ibpr_ctrl #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .fire         (fire),
    .pixel_in     (in_bus.pixel_in),
    .is_fill      (in_bus.is_fill),
    .frame_width  (frame_width),
    .frame_height (frame_height),
    .restart      (restart),
    .step         (step),
    .col          (col),
    .pix          (pix),
    .tag          (tag)
  );

  ibpr_linebuf #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_linebuf (
    .clk      (clk),
    .rst_n    (rst_n),
    .step     (step),
    .col      (col),
    .pix      (pix),
    .tag      (tag),
    .s1_adv   (s1_adv),
    .s1_valid (s1_valid),
    .s1_tag   (s1_tag),
    .s1_pix   (s1_pix),
    .col_up   (col_up),
    .col_mid  (col_mid)
  );

  ibpr_window u_window (
    .clk       (clk),
    .rst_n     (rst_n),
    .s1_valid  (s1_valid),
    .s1_tag    (s1_tag),
    .s1_pix    (s1_pix),
    .col_up    (col_up),
    .col_mid   (col_mid),
    .s1_adv    (s1_adv),
    .out_valid (out_bus.valid),
    .out_pixel (out_bus.pixel_out),
    .out_last  (out_bus.last_of_frame),
    .out_ready (out_bus.ready)
  );

endmodule
`default_nettype wire
